[design/shpa_pkg.sv]
// Shared types and constants for the stepper homing and position axis.
// Used by shpa_cfg, shpa_core and stepper_homing_position_axis; no dependencies.
`default_nettype none

package shpa_pkg;

	// Widths of the item fields and registers.
	localparam int PosW  = 16;
	localparam int HalfW = 16;
	localparam int CfgW  = 16;
	localparam int IdxW  = 2;

	// Input function codes.
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_HOME  = 2'd1;
	localparam logic [1:0] FUNC_MOVE  = 2'd2;
	localparam logic [1:0] FUNC_LIMIT = 2'd3;

	// Reply codes.
	localparam logic [1:0] REPLY_NONE     = 2'd0;
	localparam logic [1:0] REPLY_ACCEPTED = 2'd1;
	localparam logic [1:0] REPLY_REJECTED = 2'd2;

	// Configuration register indexes.
	localparam logic [IdxW-1:0] REG_HOMING_HALF = 2'd0;
	localparam logic [IdxW-1:0] REG_MOVE_HALF   = 2'd1;
	localparam logic [IdxW-1:0] REG_MAX_TRAVEL  = 2'd2;

	// Register values after reset.
	localparam logic [HalfW-1:0] HOMING_HALF_RST = 16'd4999;
	localparam logic [HalfW-1:0] MOVE_HALF_RST   = 16'd1249;
	localparam logic [PosW-1:0]  MAX_TRAVEL_RST  = 16'd20000;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_HOMING  = 2'd1,
		MODE_MOVING  = 2'd2,
		MODE_FAULTED = 2'd3
	} mode_t;

	typedef struct packed {
		logic [HalfW-1:0] homing_half_period;
		logic [HalfW-1:0] move_half_period;
		logic [PosW-1:0]  max_travel;
	} cfg_t;

	typedef struct packed {
		logic            step_level;
		logic            direction;
		mode_t           axis_state;
		logic [PosW-1:0] position;
		logic            homed;
		logic [1:0]      reply;
	} res_t;

endpackage

`default_nettype wire

[design/shpa_cfg.sv]
// Configuration register file of the axis: half periods and travel limit.
// Depends on shpa_pkg.
`default_nettype none

module shpa_cfg
	import shpa_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0] cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	// Register writes; an index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.homing_half_period <= HOMING_HALF_RST;
			cfg_q.move_half_period   <= MOVE_HALF_RST;
			cfg_q.max_travel         <= MAX_TRAVEL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HOMING_HALF: cfg_q.homing_half_period <= cfg_data;
				REG_MOVE_HALF:   cfg_q.move_half_period   <= cfg_data;
				REG_MAX_TRAVEL:  cfg_q.max_travel         <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/shpa_core.sv]
// Axis state registers and the next-state logic for one transaction.
// Depends on shpa_pkg.
`default_nettype none

module shpa_core
	import shpa_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            adv,
	input  wire logic [1:0]      func,
	input  wire logic [PosW-1:0] target,
	input  wire cfg_t            cfg,
	output res_t                 res
);

	mode_t            mode_q, mode_d;
	logic [PosW-1:0]  pos_q, pos_d;
	logic [PosW-1:0]  goal_q, goal_d;
	logic             homed_q, homed_d;
	logic             step_q, step_d;
	logic             phase_q, phase_d;
	logic             dir_q, dir_d;
	logic [HalfW-1:0] div_q, div_d;
	logic [1:0]       reply;
	logic [HalfW-1:0] half;
	logic [PosW:0]    pos_inc;
	logic [PosW-1:0]  pos_dec;
	logic [PosW-1:0]  pos_step;

	// Next state for the transaction held in the input register.
	always_comb begin
		mode_d   = mode_q;
		pos_d    = pos_q;
		goal_d   = goal_q;
		homed_d  = homed_q;
		step_d   = step_q;
		phase_d  = phase_q;
		dir_d    = dir_q;
		div_d    = div_q;
		reply    = REPLY_NONE;
		half     = (mode_q == MODE_HOMING) ? cfg.homing_half_period : cfg.move_half_period;
		pos_inc  = {1'b0, pos_q} + {{PosW{1'b0}}, 1'b1};
		pos_dec  = pos_q - {{(PosW-1){1'b0}}, 1'b1};
		pos_step = (goal_q >= pos_q) ? pos_inc[PosW-1:0] : pos_dec;
		case (func)
			FUNC_TICK: begin
				if (mode_q == MODE_HOMING || mode_q == MODE_MOVING) begin
					if (div_q >= half) begin
						div_d   = '0;
						step_d  = ~step_q;
						phase_d = ~phase_q;
						// Every second toggle is one full step.
						if (!phase_q) begin
							if (mode_q == MODE_HOMING) begin
								if (pos_inc > {1'b0, cfg.max_travel}) begin
									mode_d = MODE_FAULTED;
								end
								pos_d = pos_inc[PosW] ? {PosW{1'b1}} : pos_inc[PosW-1:0];
							end else begin
								pos_d = pos_step;
								if (pos_step == goal_q) begin
									mode_d = MODE_IDLE;
								end
							end
						end
					end else begin
						div_d = div_q + {{(HalfW-1){1'b0}}, 1'b1};
					end
				end
			end
			FUNC_HOME: begin
				mode_d = MODE_HOMING;
				pos_d  = '0;
				dir_d  = 1'b0;
				div_d  = '0;
				reply  = REPLY_ACCEPTED;
			end
			FUNC_MOVE: begin
				if (!homed_q) begin
					reply = REPLY_REJECTED;
				end else begin
					goal_d = target;
					dir_d  = (target >= pos_q);
					div_d  = '0;
					mode_d = (target == pos_q) ? MODE_IDLE : MODE_MOVING;
					reply  = REPLY_ACCEPTED;
				end
			end
			FUNC_LIMIT: begin
				// The limit switch only counts while homing.
				if (mode_q == MODE_HOMING) begin
					pos_d   = '0;
					homed_d = 1'b1;
					mode_d  = MODE_IDLE;
				end
			end
			default: ;
		endcase
	end

	// State update once per transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			goal_q  <= '0;
			homed_q <= 1'b0;
			step_q  <= 1'b0;
			phase_q <= 1'b0;
			dir_q   <= 1'b0;
			div_q   <= '0;
		end else if (adv) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			goal_q  <= goal_d;
			homed_q <= homed_d;
			step_q  <= step_d;
			phase_q <= phase_d;
			dir_q   <= dir_d;
			div_q   <= div_d;
		end
	end

	// Result fields show the state after this transaction.
	always_comb begin
		res.step_level = step_d;
		res.direction  = dir_d;
		res.axis_state = mode_d;
		res.position   = pos_d;
		res.homed      = homed_d;
		res.reply      = reply;
	end

	// Once homed, the mark stays until reset.
	a_homed_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		homed_q |=> homed_q)
		else $error("homed mark cleared");

	// A fault is only ever entered from a homing run.
	a_fault_from_homing: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_FAULTED) && ($past(mode_q) != MODE_FAULTED)
		|-> $past(mode_q) == MODE_HOMING)
		else $error("fault entered outside homing");

	// A home command zeroes the position and turns the direction to reverse.
	a_home_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (func == FUNC_HOME) |=> (pos_q == '0) && !dir_q && (mode_q == MODE_HOMING))
		else $error("home command did not restart the run");

	// Position and state do not change between transactions.
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(pos_q) && $stable(mode_q) && $stable(div_q))
		else $error("state changed without a transaction");

endmodule

`default_nettype wire

[design/stepper_homing_position_axis.sv]
// Top level of the stepper homing and position axis: input register, core and
// output register. Depends on shpa_pkg, shpa_cfg and shpa_core.
//
//   channel | signals                                   | direction
//   in      | in_valid, in_ready, func, target          | into the block
//   out     | out_valid, out_ready, step_level, ...     | out of the block
//   cfg     | cfg_we, cfg_index, cfg_data               | into the block
//
// One transaction per cycle in, one result per cycle out while out_ready stays high;
// out_valid rises when the input register's item advances, with the state update and
// output register load at the same edge. The axis state loop closes inside shpa_core.
// Reset clears the axis state and loads the register defaults; no clearing pass.
// A stalled output holds its result while one more item may wait in the input
// register; in_ready falls only when both registers are full and out_ready is low.
`default_nettype none

module stepper_homing_position_axis
	import shpa_pkg::*;
(
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output      logic            in_ready,
	input  wire logic [1:0]      func,
	input  wire logic [PosW-1:0] target,
	output      logic            out_valid,
	input  wire logic            out_ready,
	output      logic            step_level,
	output      logic            direction,
	output      logic [1:0]      axis_state,
	output      logic [PosW-1:0] position,
	output      logic            homed,
	output      logic [1:0]      reply,
	input  wire logic            cfg_we,
	input  wire logic [IdxW-1:0] cfg_index,
	input  wire logic [CfgW-1:0] cfg_data
);

	logic            s1_valid_q;
	logic [1:0]      func_s1;
	logic [PosW-1:0] target_s1;
	logic            s2_valid_q;
	res_t            res_s2;
	res_t            res;
	cfg_t            cfg;
	logic            s2_load;
	logic            adv;

	// Pipeline flow control.
	assign s2_load  = !s2_valid_q || out_ready;
	assign adv      = s1_valid_q && s2_load;
	assign in_ready = !s1_valid_q || s2_load;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			func_s1   <= func;
			target_s1 <= target;
		end
	end

	shpa_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	shpa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.func   (func_s1),
		.target (target_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_load) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid  = s2_valid_q;
	assign step_level = res_s2.step_level;
	assign direction  = res_s2.direction;
	assign axis_state = res_s2.axis_state;
	assign position   = res_s2.position;
	assign homed      = res_s2.homed;
	assign reply      = res_s2.reply;

endmodule

`default_nettype wire
